@@ sv/aifp_pkg.sv @@
// ----------------------------------------------------------------------------
// aifp_pkg: shared types and helpers of the ascii integer field parser
// Base codes, character class bundle and the per-digit accumulate step.
// ----------------------------------------------------------------------------
package aifp_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned DIGIT_BITS = 5;

  // base_mode / active_base codes
  localparam logic [1:0] BASE_AUTO = 2'd0;
  localparam logic [1:0] BASE_OCT  = 2'd1;
  localparam logic [1:0] BASE_DEC  = 2'd2;
  localparam logic [1:0] BASE_HEX  = 2'd3;

  // configuration register indexes
  localparam logic REG_BASE_MODE = 1'b0;
  localparam logic REG_MAX_WIDTH = 1'b1;

  // digit value of a byte that is no digit at all
  localparam logic [DIGIT_BITS-1:0] DIGIT_NONE = 5'd16;

  typedef struct packed {
    logic                  is_space;
    logic                  is_plus;
    logic                  is_minus;
    logic                  is_zero;
    logic                  is_x;
    logic [DIGIT_BITS-1:0] digit;
  } char_class_t;

  // digit fits the radix of the given base code
  function automatic logic digit_ok(logic [DIGIT_BITS-1:0] d, logic [1:0] base);
    logic ok;
    case (base)
      BASE_OCT: ok = (d < 5'd8);
      BASE_HEX: ok = (d < 5'd16);
      default:  ok = (d < 5'd10);
    endcase
    return ok;
  endfunction

  // acc * radix + d, radix by shift-add, wraps at VALUE_BITS
  function automatic logic [VALUE_BITS-1:0] acc_step(logic [VALUE_BITS-1:0] acc,
                                                     logic [1:0] base,
                                                     logic [DIGIT_BITS-1:0] d);
    logic [VALUE_BITS-1:0] scaled;
    case (base)
      BASE_OCT: scaled = acc << 3;
      BASE_HEX: scaled = acc << 4;
      default:  scaled = (acc << 3) + (acc << 1);
    endcase
    return scaled + VALUE_BITS'(d);
  endfunction

endpackage

@@ sv/aifp_char_decode.sv @@
// ----------------------------------------------------------------------------
// aifp_char_decode: character classifier
// Flags whitespace, sign, zero and x characters and gives the hex digit value.
// ----------------------------------------------------------------------------
module aifp_char_decode (
  input  logic [7:0]          char_i,
  output aifp_pkg::char_class_t class_o
);

  always_comb begin
    class_o.is_space = (char_i == 8'd32) || (char_i inside {[8'd9:8'd13]});
    class_o.is_plus  = (char_i == 8'h2b);
    class_o.is_minus = (char_i == 8'h2d);
    class_o.is_zero  = (char_i == 8'h30);
    class_o.is_x     = (char_i == 8'h78) || (char_i == 8'h58);
    if (char_i inside {[8'h30:8'h39]}) begin
      class_o.digit = aifp_pkg::DIGIT_BITS'(char_i - 8'h30);
    end else if (char_i inside {[8'h61:8'h66]}) begin
      class_o.digit = aifp_pkg::DIGIT_BITS'(char_i - 8'h57);
    end else if (char_i inside {[8'h41:8'h46]}) begin
      class_o.digit = aifp_pkg::DIGIT_BITS'(char_i - 8'h37);
    end else begin
      class_o.digit = aifp_pkg::DIGIT_NONE;
    end
  end

endmodule

@@ sv/ascii_integer_field_parser_unit.sv @@
// ----------------------------------------------------------------------------
// ascii_integer_field_parser_unit: streaming scanf-style integer field parser
// Parses one signed integer per field from a byte stream, octal/dec/hex/auto.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one character per transaction in tdata; tlast marks the
//    end of the stream (its character is ignored).
//  - m_axis carries one result per finished field: success, value, whether
//    the ending character was used up, and the running character count.
//    When ender_consumed is 0 the same character must be sent again.
//  - cfg writes base_mode (index 0) and max_width (index 1); cfg_ready_o is
//    always high. Write only while the parser is idle.
//  - a character is registered at the input and parsed from that register
//    when the result register can take it, and its result is registered.
//  - throughput: one character per cycle unless m_axis stalls, set by the parse
//    step (classify, shift-add accumulate, width count) between the two registers.
//  - reset: skipping-whitespace phase, base_mode 2 (decimal), max_width 0
//    (unlimited), character count 0.
//  - a stalled m_axis holds its result; one more character may sit in the
//    input register, after which s_axis_tready_o drops.
module ascii_integer_field_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_addr_i,
  input  logic [7:0]  cfg_data_i,
  // character stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // char_code[7:0]
  input  logic        s_axis_tlast_i,   // end_of_input
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // success[0], parsed_value[32:1], ender_consumed[33], chars_consumed[49:34]
  output logic [55:0] m_axis_tdata_o
);

  typedef enum logic [2:0] {
    PH_WS,
    PH_SIGNED,
    PH_ZERO,
    PH_PREFIX,
    PH_DIGITS
  } phase_e;

  localparam int unsigned VB = aifp_pkg::VALUE_BITS;
  localparam int unsigned CB = aifp_pkg::COUNT_BITS;

  // configuration
  logic [1:0] base_mode_q;
  logic [7:0] max_width_q;

  // input register
  logic       in_valid_q;
  logic [7:0] in_char_q;
  logic       in_eoi_q;

  // field state
  phase_e        ph_q, ph_d;
  logic [VB-1:0] acc_q, acc_d;
  logic          neg_q, neg_d;
  logic [1:0]    base_q, base_d;
  logic [7:0]    wl_q, wl_d;
  logic [CB-1:0] cnt_q, cnt_d;

  // result register
  logic          out_valid_q;
  logic          out_ok_q, out_ok_d;
  logic [31:0]   out_val_q, out_val_d;
  logic          out_cons_q, out_cons_d;
  logic [CB-1:0] out_cnt_q;

  logic emit;
  logic fire;

  aifp_pkg::char_class_t cls;

  aifp_char_decode u_decode (
    .char_i  (in_char_q),
    .class_o (cls)
  );

  assign cfg_ready_o     = 1'b1;
  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;

  always_comb begin
    logic          go_signed;
    logic          go_digits;
    logic          take_v;
    logic [VB-1:0] val;
    ph_d       = ph_q;
    acc_d      = acc_q;
    neg_d      = neg_q;
    base_d     = base_q;
    wl_d       = wl_q;
    cnt_d      = cnt_q;
    emit       = 1'b0;
    out_ok_d   = 1'b0;
    out_cons_d = 1'b0;
    out_val_d  = '0;
    go_signed  = 1'b0;
    go_digits  = 1'b0;
    take_v     = 1'b0;
    val        = '0;

    case (ph_q)
      PH_SIGNED: go_signed = 1'b1;
      PH_ZERO: begin
        if (in_eoi_q) begin
          emit     = 1'b1;
          out_ok_d = 1'b1;
        end else if (cls.is_x) begin
          base_d = aifp_pkg::BASE_HEX;
          ph_d   = PH_PREFIX;
          take_v = 1'b1;
        end else begin
          if (base_d == aifp_pkg::BASE_AUTO) base_d = aifp_pkg::BASE_OCT;
          ph_d      = PH_DIGITS;
          go_digits = 1'b1;
        end
      end
      PH_PREFIX: begin
        if (in_eoi_q || !aifp_pkg::digit_ok(cls.digit, aifp_pkg::BASE_HEX)) begin
          emit = 1'b1;
        end else begin
          acc_d  = VB'(cls.digit);
          ph_d   = PH_DIGITS;
          take_v = 1'b1;
        end
      end
      PH_DIGITS: go_digits = 1'b1;
      default: begin
        if (in_eoi_q) begin
          emit = 1'b1;
        end else if (cls.is_space) begin
          if (cnt_q != {CB{1'b1}}) cnt_d = cnt_q + 1'b1;
        end else begin
          // field starts: sample configuration
          acc_d  = '0;
          neg_d  = 1'b0;
          base_d = base_mode_q;
          wl_d   = max_width_q;
          if (cls.is_plus || cls.is_minus) begin
            neg_d  = cls.is_minus;
            ph_d   = PH_SIGNED;
            take_v = 1'b1;
          end else begin
            go_signed = 1'b1;
          end
        end
      end
    endcase

    if (go_signed) begin
      if (in_eoi_q) begin
        emit = 1'b1;
      end else if (cls.is_zero &&
                   (base_d == aifp_pkg::BASE_AUTO || base_d == aifp_pkg::BASE_HEX)) begin
        acc_d  = '0;
        ph_d   = PH_ZERO;
        take_v = 1'b1;
      end else begin
        if (base_d == aifp_pkg::BASE_AUTO) base_d = aifp_pkg::BASE_DEC;
        if (!aifp_pkg::digit_ok(cls.digit, base_d)) begin
          emit = 1'b1;
        end else begin
          acc_d  = VB'(cls.digit);
          ph_d   = PH_DIGITS;
          take_v = 1'b1;
        end
      end
    end

    if (go_digits) begin
      if (in_eoi_q || !aifp_pkg::digit_ok(cls.digit, base_d)) begin
        emit     = 1'b1;
        out_ok_d = 1'b1;
      end else begin
        acc_d  = aifp_pkg::acc_step(acc_d, base_d, cls.digit);
        take_v = 1'b1;
      end
    end

    // width limit counts every consumed character of the field
    if (take_v) begin
      if (cnt_q != {CB{1'b1}}) cnt_d = cnt_q + 1'b1;
      if (wl_d != 8'd0) begin
        wl_d = wl_d - 8'd1;
        if (wl_d == 8'd0) begin
          emit       = 1'b1;
          out_cons_d = 1'b1;
          out_ok_d   = (ph_d == PH_ZERO) || (ph_d == PH_DIGITS);
        end
      end
    end

    if (emit) begin
      val = neg_d ? (~acc_d + 1'b1) : acc_d;
      if (out_ok_d) out_val_d = 32'(signed'(val));
      ph_d   = PH_WS;
      acc_d  = '0;
      neg_d  = 1'b0;
      base_d = base_mode_q;
      wl_d   = max_width_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_mode_q <= aifp_pkg::BASE_DEC;
      max_width_q <= 8'd0;
      in_valid_q  <= 1'b0;
      ph_q        <= PH_WS;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      base_q      <= aifp_pkg::BASE_DEC;
      wl_q        <= 8'd0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_addr_i)
          aifp_pkg::REG_BASE_MODE: base_mode_q <= cfg_data_i[1:0];
          aifp_pkg::REG_MAX_WIDTH: max_width_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        ph_q   <= ph_d;
        acc_q  <= acc_d;
        neg_q  <= neg_d;
        base_q <= base_d;
        wl_q   <= wl_d;
        cnt_q  <= cnt_d;
        out_valid_q <= emit;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_char_q <= s_axis_tdata_i;
      in_eoi_q  <= s_axis_tlast_i;
    end
    if (fire && emit) begin
      out_ok_q   <= out_ok_d;
      out_val_q  <= out_val_d;
      out_cons_q <= out_cons_d;
      out_cnt_q  <= cnt_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_cnt_q, out_cons_q, out_val_q, out_ok_q};

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: ascii integer field parser unit
// Streams characters into the parser and compares every result transaction
// field by field against an in-bench model of the scanf-style field parse,
// under several base and width settings and varying stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;

  typedef enum logic [2:0] {
    SCAN_BLANK, SCAN_SIGN, SCAN_LEAD_ZERO, SCAN_PREFIX, SCAN_DIGITS
  } scan_phase_e;

  typedef struct packed {
    logic        success;
    logic [31:0] value;
    logic        consumed;
    logic [15:0] count;
  } field_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_addr_i = 1'b0;
  logic [7:0]  cfg_data_i = 8'd0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'd0;   // char_code[7:0]
  logic        s_axis_tlast_i = 1'b0;   // end_of_input
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // success[0], parsed_value[32:1], ender_consumed[33], chars_consumed[49:34]
  logic [55:0] m_axis_tdata_o;

  ascii_integer_field_parser_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  // parser model state
  logic [1:0]  cfg_base;
  logic [7:0]  cfg_width;
  scan_phase_e scan_phase;
  logic [31:0] acc;
  logic        neg;
  logic [1:0]  cur_base;
  logic [7:0]  width_left;
  logic [15:0] char_total;

  field_result_t pending_fields[$];
  int unsigned   mismatches = 0;
  int unsigned   chars_sent = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;

  function automatic logic [4:0] radix_of(input logic [1:0] base);
    case (base)
      aifp_pkg::BASE_OCT: return 5'd8;
      aifp_pkg::BASE_HEX: return 5'd16;
      default:            return 5'd10;
    endcase
  endfunction

  function automatic void restart_field();
    scan_phase = SCAN_BLANK;
    acc        = '0;
    neg        = 1'b0;
    cur_base   = cfg_base;
    width_left = cfg_width;
  endfunction

  function automatic bit close_field(input bit ok, input bit used, output field_result_t r);
    logic [31:0] v;
    v = neg ? -acc : acc;
    r.success  = ok;
    r.value    = ok ? v : '0;
    r.consumed = used;
    r.count    = char_total;
    restart_field();
    return 1'b1;
  endfunction

  // count one used character; the field closes once the width is used up
  function automatic bit take_char(output field_result_t r);
    if (char_total != 16'hFFFF) char_total++;
    if (width_left != 8'd0) begin
      width_left--;
      if (width_left == 8'd0)
        return close_field(scan_phase == SCAN_LEAD_ZERO || scan_phase == SCAN_DIGITS, 1'b1, r);
    end
    return 1'b0;
  endfunction

  function automatic bit predict_field(input logic [7:0] c, input logic eoi,
                                       output field_result_t r);
    logic [4:0]  d;
    scan_phase_e ph;
    d = 5'd16;
    if (c >= "0" && c <= "9") d = 5'(c - "0");
    else if (c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
    ph = scan_phase;

    if (ph == SCAN_BLANK) begin
      if (eoi) return close_field(1'b0, 1'b0, r);
      if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
        if (char_total != 16'hFFFF) char_total++;
        return 1'b0;
      end
      // first non-blank character picks up the current settings
      restart_field();
      if (c == "-" || c == "+") begin
        neg = (c == "-");
        scan_phase = SCAN_SIGN;
        return take_char(r);
      end
      ph = SCAN_SIGN;
    end

    if (ph == SCAN_SIGN) begin
      if (eoi) return close_field(1'b0, 1'b0, r);
      if (c == "0" &&
          (cur_base == aifp_pkg::BASE_AUTO || cur_base == aifp_pkg::BASE_HEX)) begin
        acc = '0;
        scan_phase = SCAN_LEAD_ZERO;
        return take_char(r);
      end
      if (cur_base == aifp_pkg::BASE_AUTO) cur_base = aifp_pkg::BASE_DEC;
      if (d >= radix_of(cur_base)) return close_field(1'b0, 1'b0, r);
      acc = 32'(d);
      scan_phase = SCAN_DIGITS;
      return take_char(r);
    end

    if (ph == SCAN_PREFIX) begin
      if (eoi || d >= 5'd16) return close_field(1'b0, 1'b0, r);
      acc = 32'(d);
      scan_phase = SCAN_DIGITS;
      return take_char(r);
    end

    if (ph == SCAN_LEAD_ZERO) begin
      if (eoi) return close_field(1'b1, 1'b0, r);
      if (c == "x" || c == "X") begin
        cur_base = aifp_pkg::BASE_HEX;
        scan_phase = SCAN_PREFIX;
        return take_char(r);
      end
      if (cur_base == aifp_pkg::BASE_AUTO) cur_base = aifp_pkg::BASE_OCT;
      scan_phase = SCAN_DIGITS;
    end

    if (eoi || d >= radix_of(cur_base)) return close_field(1'b1, 1'b0, r);
    acc = acc * radix_of(cur_base) + 32'(d);
    return take_char(r);
  endfunction

  function automatic logic [7:0] blank_char();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? 8'd32 : 8'(9 + k);
  endfunction

  function automatic logic [7:0] digit_char(input int unsigned v);
    logic [7:0] ch;
    if (v < 10) ch = "0" + 8'(v);
    else ch = "a" + 8'(v - 10);
    if (v >= 10 && $urandom_range(0, 1) == 1) ch = ch - 8'd32;
    return ch;
  endfunction

  // called at a falling edge; leaves tvalid high for a back-to-back follow-up
  task automatic push_char(input logic [7:0] code, input logic eoi);
    field_result_t res;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= code;
    s_axis_tlast_i  <= eoi;
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (predict_field(code, eoi, res)) pending_fields.push_back(res);
    chars_sent++;
    @(negedge clk_i);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0);
  endtask

  task automatic settle();
    int unsigned waited;
    waited = 0;
    s_axis_tvalid_i <= 1'b0;
    while (pending_fields.size() != 0 && waited < 20000) begin
      @(negedge clk_i);
      waited++;
    end
    if (pending_fields.size() != 0) begin
      $error("%0d expected results never arrived", pending_fields.size());
      mismatches++;
      pending_fields.delete();
    end
    // a character that closes no field may still be in the pipeline
    repeat (6) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [1:0] base, input logic [7:0] width);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= aifp_pkg::REG_BASE_MODE;
    cfg_data_i  <= {6'($urandom), base};
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_base = base;
    @(negedge clk_i);
    cfg_addr_i <= aifp_pkg::REG_MAX_WIDTH;
    cfg_data_i <= width;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_width = width;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_field();
    int unsigned n_digits;
    int unsigned v;
    logic [1:0]  digit_base;
    // noise
    if ($urandom_range(0, 9) < 2) begin
      repeat ($urandom_range(1, 4))
        push_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
      return;
    end
    repeat ($urandom_range(0, 2)) push_char(blank_char(), 1'b0);
    case ($urandom_range(0, 3))
      0:       push_char("-", 1'b0);
      1:       push_char("+", 1'b0);
      default: ;
    endcase
    digit_base = (cfg_base == aifp_pkg::BASE_AUTO) ? aifp_pkg::BASE_DEC : cfg_base;
    case ($urandom_range(0, 5))
      0: begin
        push_char("0", 1'b0);
        push_char(($urandom_range(0, 1) == 1) ? "x" : "X", 1'b0);
        digit_base = aifp_pkg::BASE_HEX;
      end
      1: begin
        push_char("0", 1'b0);
        if (cfg_base == aifp_pkg::BASE_AUTO) digit_base = aifp_pkg::BASE_OCT;
      end
      default: ;
    endcase
    // long runs can wrap the accumulator
    case ($urandom_range(0, 9))
      0:       n_digits = 0;
      1:       n_digits = $urandom_range(9, 14);
      default: n_digits = $urandom_range(1, 6);
    endcase
    repeat (n_digits) begin
      if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 15);
      else v = $urandom_range(0, radix_of(digit_base) - 1);
      push_char(digit_char(v), 1'b0);
    end
    case ($urandom_range(0, 4))
      0:       push_char(blank_char(), 1'b0);
      1:       push_char(8'($urandom_range(0, 255)), 1'b1);
      2:       push_char(8'($urandom_range(0, 255)), 1'b0);
      default: ;
    endcase
  endtask

  task automatic test_directed_cases();
    // reset settings: decimal, unlimited width
    push_char(8'd9, 1'b0);
    push_text("+12");
    push_char(8'd13, 1'b0);
    push_char(8'h5a, 1'b1);   // end of stream while skipping blanks
    settle();
    set_config(aifp_pkg::BASE_AUTO, 8'd0);
    push_text("0xG");         // prefix with no digit after it
    push_text("0 ");          // lone zero
    push_char("-", 1'b0);     // sign with no digit
    push_char(8'h00, 1'b1);
    push_char(8'hff, 1'b0);   // high byte is neither blank nor digit
    push_text("017z");        // leading zero selects octal
    settle();
    set_config(aifp_pkg::BASE_HEX, 8'd3);
    push_text("-fF9");        // width runs out on the third character
    push_char(8'hff, 1'b1);
    settle();
    set_config(aifp_pkg::BASE_OCT, 8'd1);
    push_text("+8");
    settle();
  endtask

  task automatic test_random_traffic(input int unsigned send_pct, input int unsigned recv_pct,
                                     input int unsigned round);
    logic [1:0]  bases[4];
    logic [7:0]  width;
    int unsigned stop_at;
    bases = '{aifp_pkg::BASE_AUTO, aifp_pkg::BASE_OCT, aifp_pkg::BASE_DEC,
              aifp_pkg::BASE_HEX};
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int k = 0; k < 4; k++) begin
      case (k)
        0:       width = 8'd0;
        1:       width = 8'($urandom_range(1, 3));
        2:       width = 8'd255;
        default: width = 8'($urandom_range(4, 12));
      endcase
      set_config(bases[(k + round) % 4], width);
      stop_at = chars_sent + 154;
      while (chars_sent < stop_at) send_random_field();
      // back to the blank-skipping phase before the next setting
      push_char(8'($urandom_range(0, 255)), 1'b1);
      settle();
    end
  endtask

  always @(negedge clk_i) m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle_pct);

  always @(posedge clk_i) begin
    field_result_t want;
    field_result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got.success  = m_axis_tdata_o[0];
      got.value    = m_axis_tdata_o[32:1];
      got.consumed = m_axis_tdata_o[33];
      got.count    = m_axis_tdata_o[49:34];
      if (pending_fields.size() == 0) begin
        $error("unexpected result transaction: %h", m_axis_tdata_o);
        mismatches++;
      end else begin
        want = pending_fields.pop_front();
        if (got.success !== want.success) begin
          $error("success: expected %0d, got %0d", want.success, got.success);
          mismatches++;
        end
        if (got.value !== want.value) begin
          $error("parsed_value: expected %0d, got %0d",
                 $signed(want.value), $signed(got.value));
          mismatches++;
        end
        if (got.consumed !== want.consumed) begin
          $error("ender_consumed: expected %0d, got %0d", want.consumed, got.consumed);
          mismatches++;
        end
        if (got.count !== want.count) begin
          $error("chars_consumed: expected %0d, got %0d", want.count, got.count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cfg_base   = aifp_pkg::BASE_DEC;
    cfg_width  = 8'd0;
    char_total = 16'd0;
    restart_field();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed_cases();
    test_random_traffic(35, 82, 0);
    test_random_traffic(82, 35, 1);
    test_random_traffic(0, 0, 2);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
